/* rtl/orma_pkg.sv */
// Package for the outlier-rejecting moving average.
// Holds the widths, window depth and controller state type; no dependencies.
`default_nettype none

package orma_pkg;

  // Window depth and field widths.
  localparam int WINDOW_DEPTH = 10;
  localparam int SAMPLE_W     = 16;
  localparam int AVG_W        = 16;
  localparam int HELD_W       = 4;

  // Count holds 0..WINDOW_DEPTH; the sum holds WINDOW_DEPTH full-scale samples.
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = $clog2(WINDOW_DEPTH * ((1 << SAMPLE_W) - 1) + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);

  // Bound products: sample*10 and last*11 fit in SAMPLE_W + 4 bits.
  localparam int PROD_W = SAMPLE_W + 4;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [SUM_W-1:0]    sum_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_e;

endpackage : orma_pkg

`default_nettype wire

/* rtl/orma_cell.sv */
// One window cell: holds a stored sample and passes it to the next cell on a shift.
// Depends on orma_pkg.
`default_nettype none

module orma_cell (
  input  wire                    clk_i,
  input  wire                    shift_i,
  input  wire  orma_pkg::sample_t data_i,
  output orma_pkg::sample_t      data_o
);
  import orma_pkg::*;

  sample_t data_q;

  // Take the neighbor's sample whenever the chain advances.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule : orma_cell

`default_nettype wire

/* rtl/orma_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle over the SUM_W bits of the dividend.
// Depends on orma_pkg.
`default_nettype none

module orma_div (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire  orma_pkg::sum_t   dividend_i,
  input  wire  orma_pkg::count_t divisor_i,
  output logic                 done_o,
  output orma_pkg::sum_t       quotient_o
);
  import orma_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  sum_t                dq_q;
  count_t              div_q;
  count_t              rem_q;

  logic [CNT_W:0]      trial;
  logic                fits;
  logic [CNT_W:0]      diff;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem_q, dq_q[SUM_W-1]};
    fits  = (trial >= {1'b0, div_q});
    diff  = trial - {1'b0, div_q};
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(SUM_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule : orma_div

`default_nettype wire

/* rtl/outlier_rejecting_moving_average.sv */
// Outlier-rejecting moving average: top level with controller, cell chain and divider.
// Depends on orma_pkg, orma_cell and orma_div.
//
// Usage:
//   Input channel: sample_i with in_valid_i / in_ready_o; one beat is one sensor sample.
//   Output channel: average_o, accepted_o, held_count_o with out_valid_o / out_ready_i;
//   every input beat yields exactly one output beat.
//   cfg_we_i / cfg_wdata_i write switch_mode; write only while idle.
//   A beat passes the outlier test and window update (S_UPD), the divider load
//   (S_LOAD), the bit-serial divider over the SUM_W (20) bits of the sum (S_DIV), the
//   controller seeing the divider finish, and the fill of the output register (S_OUT).
//   The divider's one-bit-per-cycle loop takes most of that time. One sample is in
//   work at a time: the next beat is taken only once the controller is back in idle.
//   The output register parts the channels: a new sample is taken while a finished
//   result still waits; if the receiver stalls, the next result waits in the
//   controller until the output register frees up.
//   Reset clears the count, the sum, the last stored sample and switch_mode; the
//   window cells are not cleared, since only cells below the count are ever used.
`default_nettype none

module outlier_rejecting_moving_average (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire                    cfg_wdata_i,
  input  wire  [orma_pkg::SAMPLE_W-1:0] sample_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  output logic [orma_pkg::AVG_W-1:0]    average_o,
  output logic                   accepted_o,
  output logic [orma_pkg::HELD_W-1:0]   held_count_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i
);
  import orma_pkg::*;

  state_e  state_q, state_d;
  logic    switch_q;
  sample_t smp_q;
  sample_t last_q, last_d;
  count_t  cnt_q, cnt_d;
  sum_t    sum_q, sum_d;
  logic    take_q, take_d;

  logic    upd_en;
  logic    div_start;
  logic    out_load;

  logic    div_done;
  sum_t    div_quo;

  logic [AVG_W-1:0]  avg_q;
  logic              acc_q;
  logic [HELD_W-1:0] held_q;
  logic              out_valid_q;

  // Window chain: cell 0 takes the new sample; in a full window the oldest sits at the far end.
  sample_t cell_in  [WINDOW_DEPTH];
  sample_t cell_out [WINDOW_DEPTH];
  logic    shift;

  assign cell_in[0] = smp_q;

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign cell_in[g] = cell_out[g-1];
    end
    orma_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .data_i  (cell_in[g]),
      .data_o  (cell_out[g])
    );
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_q <= 1'b0;
    end else if (cfg_we_i) begin
      switch_q <= cfg_wdata_i;
    end
  end

  // Capture the sample on an input beat.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= sample_i;
    end
  end

  // Outlier test and window update: sample*10 must lie within last*9 .. last*11.
  logic [PROD_W-1:0] v10, lo9, hi11;
  logic              in_band;
  logic              full;

  always_comb begin
    v10     = (PROD_W'(smp_q) << 3) + (PROD_W'(smp_q) << 1);
    lo9     = (PROD_W'(last_q) << 3) + PROD_W'(last_q);
    hi11    = lo9 + (PROD_W'(last_q) << 1);
    in_band = !((v10 < lo9) || (v10 > hi11));
    full    = (cnt_q == CNT_W'(WINDOW_DEPTH));

    take_d = take_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    last_d = last_q;
    shift  = 1'b0;
    if (upd_en) begin
      if (switch_q) begin
        take_d = 1'b1;
        shift  = 1'b1;
        cnt_d  = CNT_W'(1);
        sum_d  = SUM_W'(smp_q);
        last_d = smp_q;
      end else begin
        take_d = (cnt_q == '0) || in_band;
        if (take_d) begin
          shift  = 1'b1;
          last_d = smp_q;
          if (full) begin
            sum_d = sum_q - SUM_W'(cell_out[WINDOW_DEPTH-1]) + SUM_W'(smp_q);
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
            sum_d = sum_q + SUM_W'(smp_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      last_q <= '0;
      take_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      last_q <= last_d;
      take_q <= take_d;
    end
  end

  // Mean of the window.
  orma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Controller next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_UPD;
        end
      end
      S_UPD:  state_d = S_LOAD;
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready_o = 1'b0;
    upd_en     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_UPD:  upd_en     = 1'b1;
      S_LOAD: div_start  = 1'b1;
      S_DIV:  ;
      S_OUT:  out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register; an empty window reads as a zero mean.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q  <= (cnt_q == '0) ? '0 : div_quo[AVG_W-1:0];
      acc_q  <= take_q;
      held_q <= HELD_W'(cnt_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign average_o    = avg_q;
  assign accepted_o   = acc_q;
  assign held_count_o = held_q;

  // The window count never runs past the depth.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW_DEPTH))
    else $error("window count exceeds depth");

  // An input beat is followed by the window update.
  a_beat_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_UPD))
    else $error("input beat not followed by update");

  // The divider finishes only while the controller waits on it.
  a_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  // A result is loaded only when the output register can take it.
  a_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule : outlier_rejecting_moving_average

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for outlier_rejecting_moving_average.
// Depends on orma_pkg and the block's RTL. It predicts each result beat from the sample
// beats it accepts, and checks the results under random idling, stalls and switch settings.
`timescale 1ns / 1ps

module tb;
  import orma_pkg::*;

  // Expected contents of one result beat.
  typedef struct {
    logic [AVG_W-1:0]  average;
    logic              accepted;
    logic [HELD_W-1:0] held_count;
  } mean_beat_t;

  // Tracks the sample window, predicts each result beat and checks the beats that arrive.
  class mean_tracker;
    sample_t     win[WINDOW_DEPTH];
    int unsigned held;
    int unsigned total;
    sample_t     newest;
    bit          switch_on;
    mean_beat_t  pending_means[$];
    int          failures;
    int          n_stored;
    int          n_rejected;
    int          n_checked;

    function new();
      held = 0;
      total = 0;
      newest = '0;
      switch_on = 1'b0;
      failures = 0;
      n_stored = 0;
      n_rejected = 0;
      n_checked = 0;
    endfunction

    // Apply one accepted sample beat to the window and queue the result it causes.
    function void note_sample(sample_t s);
      mean_beat_t  r;
      bit          take;
      int unsigned v10;
      int unsigned lo;
      int unsigned hi;
      take = 1'b1;
      if (switch_on) begin
        win[0] = s;
        held = 1;
        total = s;
        newest = s;
      end else begin
        // The outlier test only applies once something is stored.
        if (held > 0) begin
          v10 = 32'(s) * 10;
          lo = 32'(newest) * 9;
          hi = 32'(newest) * 11;
          if (v10 < lo || v10 > hi) take = 1'b0;
        end
        if (take) begin
          if (held >= WINDOW_DEPTH) begin
            total -= win[0];
            for (int i = 1; i < WINDOW_DEPTH; i++) win[i-1] = win[i];
            win[WINDOW_DEPTH-1] = s;
          end else begin
            win[held] = s;
            held++;
          end
          total += s;
          newest = s;
        end
      end
      if (take) n_stored++;
      else n_rejected++;
      r.average = (held != 0) ? AVG_W'(total / held) : '0;
      r.accepted = take;
      r.held_count = HELD_W'(held);
      pending_means.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction, field by field.
    function void check_result(logic [AVG_W-1:0] avg, logic acc, logic [HELD_W-1:0] cnt);
      mean_beat_t r;
      if (pending_means.size() == 0) begin
        $error("result beat with no prediction waiting: average %0d", avg);
        failures++;
        return;
      end
      r = pending_means.pop_front();
      n_checked++;
      if (avg !== r.average) begin
        $error("average: expected %0d, got %0d", r.average, avg);
        failures++;
      end
      if (acc !== r.accepted) begin
        $error("accepted: expected %0d, got %0d", r.accepted, acc);
        failures++;
      end
      if (cnt !== r.held_count) begin
        $error("held_count: expected %0d, got %0d", r.held_count, cnt);
        failures++;
      end
    endfunction

    function int pending_count();
      return pending_means.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic [SAMPLE_W-1:0] sample_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [AVG_W-1:0]    average_o;
  logic                accepted_o;
  logic [HELD_W-1:0]   held_count_o;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;

  mean_tracker sb;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          n_switch_writes = 0;

  outlier_rejecting_moving_average dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .average_o    (average_o),
    .accepted_o   (accepted_o),
    .held_count_o (held_count_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  // Clock with a 12 ns period.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Result side: check each accepted beat, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(average_o, accepted_o, held_count_o);
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Present one sample beat, wait for it to be taken, then idle at random.
  task automatic send_sample(input sample_t s);
    int gap;
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain(input int settle);
    in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write switch_mode; only called while the block is idle.
  task automatic set_switch(input bit v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.switch_on = v;
    n_switch_writes++;
  endtask

  // Mostly samples near the newest stored one, plus band edges, extremes and noise.
  function automatic sample_t pick_sample();
    int unsigned lo;
    int unsigned hi;
    int          r;
    lo = (32'(sb.newest) * 9 + 9) / 10;
    hi = (32'(sb.newest) * 11) / 10;
    if (hi > 65535) hi = 65535;
    r = $urandom_range(0, 99);
    if (r < 55) return sample_t'($urandom_range(lo, hi));
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return sample_t'(lo);
        1: return sample_t'(hi);
        2: return sample_t'((lo > 0) ? lo - 1 : 0);
        default: return sample_t'((hi < 65535) ? hi + 1 : 65535);
      endcase
    end
    if (r < 80) return sample_t'($urandom_range(0, 15));
    if (r < 90) return sample_t'($urandom_range(65520, 65535));
    return sample_t'($urandom);
  endfunction

  // One random phase at a fixed switch setting and idling mix.
  task automatic run_phase(input bit sw, input int send_pct, input int recv_pct,
                           input int count, input int pause_at);
    set_switch(sw);
    sender_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain(0);
      send_sample(pick_sample());
    end
    // Leave a mid-range newest sample so the next filtered phase is not stuck near zero.
    if (sw) send_sample(sample_t'($urandom_range(2000, 50000)));
    drain(4);
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty window, zero newest sample and rejection against zero.
    set_switch(1'b0);
    send_sample(16'd0);
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    drain(4);

    // Switch mode replaces the whole window each beat.
    set_switch(1'b1);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    send_sample(16'd1000);
    drain(4);

    // Band edges: a sample exactly on the lower bound is stored, then samples above the upper bound are rejected.
    set_switch(1'b0);
    send_sample(16'd900);
    send_sample(16'd810);
    send_sample(16'd809);
    send_sample(16'd891);
    send_sample(16'd892);
    send_sample(16'd980);
    send_sample(16'd1078);
    drain(4);

    // Full window of full-scale samples, with the oldest one dropped.
    set_switch(1'b1);
    send_sample(16'd60000);
    drain(4);
    set_switch(1'b0);
    repeat (10) send_sample(16'hFFFF);
    drain(4);

    // Random phases across the idling mixes; one phase pauses until all results are in.
    run_phase(1'b0, 0, 0, 120, -1);
    run_phase(1'b1, 71, 0, 60, -1);
    run_phase(1'b0, 71, 0, 100, 50);
    run_phase(1'b1, 0, 71, 60, -1);
    run_phase(1'b0, 0, 71, 110, -1);
    run_phase(1'b1, 15, 15, 40, -1);
    run_phase(1'b0, 15, 15, 60, -1);

    drain(30);
    $display("Checked %0d result beats: %0d samples stored, %0d rejected as outliers,",
             sb.n_checked, sb.n_stored, sb.n_rejected);
    $display("over %0d switch_mode writes and four idling mixes.", n_switch_writes);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding", sb.pending_count());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
